// ===== rtl/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// psc_pkg
// Shared types, constants and helper functions for the preset BCD counter
// with multiplexed seven-segment scan.
// ----------------------------------------------------------------------------
package psc_pkg;

    // number of displayed digits, index 0 is the leftmost
    localparam int NUM_DIGITS   = 6;
    localparam int DIGIT_IDX_W  = 3;
    localparam int IDX_W        = $clog2(NUM_DIGITS);
    localparam int DP_DIGIT     = 2;
    localparam int PRESET_W     = 24;
    localparam int PRESET_NIBS  = PRESET_W / 4;
    localparam int CFG_INDEX_W  = 8;
    localparam int SEG_W        = 7;

    // preset reset values, packed BCD hundredths
    localparam logic [PRESET_W-1:0] PRESET_ONE_RST   = 24'h111111;
    localparam logic [PRESET_W-1:0] PRESET_TWO_RST   = 24'h222222;
    localparam logic [PRESET_W-1:0] PRESET_THREE_RST = 24'h333333;
    localparam logic [PRESET_W-1:0] PRESET_FOUR_RST  = 24'h444444;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESET_ONE   = 8'd0,
        REG_PRESET_TWO   = 8'd1,
        REG_PRESET_THREE = 8'd2,
        REG_PRESET_FOUR  = 8'd3
    } cfg_reg_t;

    // one BCD digit per entry, entry 0 is the leftmost
    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    // word passed from the front part to the scan part
    typedef struct packed {
        digits_t digits;
    } scan_item_t;

    // power-on count, digits 1 9 9 5 3 4 right aligned
    localparam logic [5:0][3:0] START_DIGITS = {4'd1, 4'd9, 4'd9, 4'd5, 4'd3, 4'd4};

    function automatic digits_t start_count();
        digits_t res;
        int      src;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            src = i - (NUM_DIGITS - 6);
            if (src >= 0 && src < 6) begin
                res[i] = START_DIGITS[5 - src];
            end else begin
                res[i] = 4'd0;
            end
        end
        return res;
    endfunction

    // unpack a preset, clamping nibbles above nine
    function automatic digits_t preset_digits(input logic [PRESET_W-1:0] packed_val);
        digits_t    res;
        int         pos;
        logic [3:0] nib;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            pos = NUM_DIGITS - 1 - i;
            nib = 4'd0;
            if (pos < PRESET_NIBS) begin
                nib = packed_val[pos*4 +: 4];
            end
            if (nib > 4'd9) begin
                nib = 4'd9;
            end
            res[i] = nib;
        end
        return res;
    endfunction

    // add one hundredth, wraps from all nines to zero
    function automatic digits_t bcd_inc(input digits_t d);
        digits_t res;
        logic    carry;
        res   = d;
        carry = 1'b1;
        for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
            if (carry) begin
                if (d[i] >= 4'd9) begin
                    res[i] = 4'd0;
                end else begin
                    res[i] = d[i] + 4'd1;
                    carry  = 1'b0;
                end
            end
        end
        return res;
    endfunction

    // gfedcba pattern, values above nine shown as nine
    function automatic logic [SEG_W-1:0] digit_segments(input logic [3:0] d);
        logic [SEG_W-1:0] seg;
        case (d)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            default: seg = 7'h6F;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/psc_front.sv =====
// ----------------------------------------------------------------------------
// psc_front
// Takes switch ticks, applies the highest priority pressed preset, hands the
// digit snapshot to the scan queue and advances the count by one hundredth.
// ----------------------------------------------------------------------------
module psc_front
    import psc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_switch_one_level,
    input  logic                   s_switch_two_level,
    input  logic                   s_switch_three_level,
    input  logic                   s_switch_four_level,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PRESET_W-1:0]    cfg_data,
    input  logic                   q_full,
    output logic                   q_push,
    output scan_item_t             q_push_item
);

    logic [PRESET_W-1:0] preset_one_reg;
    logic [PRESET_W-1:0] preset_two_reg;
    logic [PRESET_W-1:0] preset_three_reg;
    logic [PRESET_W-1:0] preset_four_reg;
    digits_t             count_reg;
    digits_t             count_next;
    digits_t             loaded;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign q_push    = s_valid && s_ready;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preset_one_reg   <= PRESET_ONE_RST;
            preset_two_reg   <= PRESET_TWO_RST;
            preset_three_reg <= PRESET_THREE_RST;
            preset_four_reg  <= PRESET_FOUR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PRESET_ONE:   preset_one_reg   <= cfg_data;
                REG_PRESET_TWO:   preset_two_reg   <= cfg_data;
                REG_PRESET_THREE: preset_three_reg <= cfg_data;
                REG_PRESET_FOUR:  preset_four_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // preset priority, switch one wins
    always_comb begin
        if (!s_switch_one_level) begin
            loaded = preset_digits(preset_one_reg);
        end else if (!s_switch_two_level) begin
            loaded = preset_digits(preset_two_reg);
        end else if (!s_switch_three_level) begin
            loaded = preset_digits(preset_three_reg);
        end else if (!s_switch_four_level) begin
            loaded = preset_digits(preset_four_reg);
        end else begin
            loaded = count_reg;
        end
    end

    assign q_push_item.digits = loaded;

    // count advance
    always_comb begin
        count_next = count_reg;
        if (q_push) begin
            count_next = bcd_inc(loaded);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= start_count();
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/psc_queue.sv =====
// ----------------------------------------------------------------------------
// psc_queue
// Two-entry queue of digit snapshots between the front and the scan part.
// ----------------------------------------------------------------------------
module psc_queue
    import psc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  scan_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output scan_item_t pop_item
);

    scan_item_t slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    // slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    // occupancy
    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_queue_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full) && !(pop && !pop_valid))
        else $error("queue overflow or underflow");
`endif

endmodule

// ===== rtl/psc_scan.sv =====
// ----------------------------------------------------------------------------
// psc_scan
// Walks one digit snapshot left to right, one registered scan word per cycle while m_ready does not stall it.
// ----------------------------------------------------------------------------
module psc_scan
    import psc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_valid,
    input  scan_item_t             q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SEG_W-1:0]       m_segment_bits,
    output logic                   m_decimal_point,
    output logic [DIGIT_IDX_W-1:0] m_digit_index,
    output logic                   m_last_digit
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DIGITS - 1);
    localparam logic [IDX_W-1:0] DP_IDX   = IDX_W'(DP_DIGIT);

    logic                   busy_reg;
    digits_t                cur_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   m_valid_reg;
    logic [SEG_W-1:0]       seg_reg;
    logic                   dp_reg;
    logic [DIGIT_IDX_W-1:0] index_reg;
    logic                   last_reg;
    logic                   out_load;
    logic                   emit_last;

    assign out_load  = busy_reg && (!m_valid_reg || m_ready);
    assign emit_last = out_load && (idx_reg == LAST_IDX);
    assign q_pop     = q_valid && (!busy_reg || emit_last);

    // snapshot and digit walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (emit_last) begin
            busy_reg <= 1'b0;
        end else if (out_load) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_item.digits;
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            seg_reg   <= digit_segments(cur_reg[idx_reg]);
            dp_reg    <= (idx_reg == DP_IDX);
            index_reg <= DIGIT_IDX_W'(idx_reg);
            last_reg  <= (idx_reg == LAST_IDX);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_segment_bits  = seg_reg;
    assign m_decimal_point = dp_reg;
    assign m_digit_index   = index_reg;
    assign m_last_digit    = last_reg;

`ifndef ASSERT_OFF
    a_last_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (last_reg == (index_reg == DIGIT_IDX_W'(NUM_DIGITS - 1))))
        else $error("last flag not on final digit");
    a_dp_on_third: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (dp_reg == (index_reg == DIGIT_IDX_W'(DP_DIGIT))))
        else $error("decimal point on wrong digit");
    a_digit_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !last_reg) |=>
            (m_valid_reg && index_reg == $past(index_reg) + DIGIT_IDX_W'(1)))
        else $error("scan word skipped or stalled mid tick");
`endif

endmodule

// ===== rtl/preset_bcd_counter_segment_scan.sv =====
// The first scan word of a tick passes the queue slot, the scan snapshot register
// and the output word register. The scan unit emits one digit word per cycle while
// m_ready does not stall it; a two-entry snapshot queue lets ticks arrive back to back.
// Reset (aresetn low, synchronous): count 1995.34, presets 1111.11..4444.44,
// queue and output empty.
// ----------------------------------------------------------------------------
// preset_bcd_counter_segment_scan
// Six-digit BCD hundredths counter with switch presets and multiplexed
// seven-segment scan output.
// ----------------------------------------------------------------------------
module preset_bcd_counter_segment_scan
    import psc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_switch_one_level,
    input  logic                   s_switch_two_level,
    input  logic                   s_switch_three_level,
    input  logic                   s_switch_four_level,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SEG_W-1:0]       m_segment_bits,
    output logic                   m_decimal_point,
    output logic [DIGIT_IDX_W-1:0] m_digit_index,
    output logic                   m_last_digit,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [PRESET_W-1:0]    cfg_data
);

    logic       q_full;
    logic       q_push;
    scan_item_t q_push_item;
    logic       q_pop;
    logic       q_valid;
    scan_item_t q_item;

    // tick intake and count
    psc_front u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_switch_one_level   (s_switch_one_level),
        .s_switch_two_level   (s_switch_two_level),
        .s_switch_three_level (s_switch_three_level),
        .s_switch_four_level  (s_switch_four_level),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .q_full               (q_full),
        .q_push               (q_push),
        .q_push_item          (q_push_item)
    );

    // snapshot queue
    psc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    // digit scan
    psc_scan u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_segment_bits  (m_segment_bits),
        .m_decimal_point (m_decimal_point),
        .m_digit_index   (m_digit_index),
        .m_last_digit    (m_last_digit)
    );

endmodule

// ===== sim/preset_bcd_counter_segment_scan_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preset_bcd_counter_segment_scan_tb
// Drives switch ticks and preset register writes into the counter and checks
// every scan word against a local model of the BCD count, the switch priority,
// the nibble clamp and the wrap. Starts with a fixed table of cases, then
// runs random phases with new preset settings and random handshake stalls.
// ----------------------------------------------------------------------------
module preset_bcd_counter_segment_scan_tb
    import psc_pkg::*;
();

    localparam int DIGITS      = 6;
    localparam int POINT_DIGIT = 2;
    localparam int PLAN_ROWS   = 26;

    // register indexes that decode to nothing
    localparam logic [CFG_INDEX_W-1:0] REG_PAST_LAST = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP       = 8'hFF;

    // power-on values, packed BCD hundredths
    localparam logic [23:0]        POWER_ON_COUNT = 24'h199534;
    localparam logic [3:0][23:0]   POWER_ON_PRESET = {24'h444444, 24'h333333,
                                                      24'h222222, 24'h111111};

    // gfedcba pattern per decimal digit, entry 0 on the right
    localparam logic [9:0][SEG_W-1:0] SEG_OF = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                                7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    // one line of the directed table; levels are switch one..four left to right
    typedef struct packed {
        row_kind_t              kind;
        logic [3:0]             levels;
        logic [CFG_INDEX_W-1:0] reg_idx;
        logic [PRESET_W-1:0]    reg_val;
        logic                   typed;
        logic [23:0]            shown;
    } plan_row_t;

    typedef struct packed {
        logic [SEG_W-1:0]       seg;
        logic                   point;
        logic [DIGIT_IDX_W-1:0] pos;
        logic                   last;
    } scan_word_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_switch_one_level;
    logic                   s_switch_two_level;
    logic                   s_switch_three_level;
    logic                   s_switch_four_level;
    logic                   m_valid;
    logic                   m_ready;
    logic [SEG_W-1:0]       m_segment_bits;
    logic                   m_decimal_point;
    logic [DIGIT_IDX_W-1:0] m_digit_index;
    logic                   m_last_digit;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [PRESET_W-1:0]    cfg_data;

    // typed expectation travelling with the tick payload
    logic                   tick_typed;
    logic [23:0]            tick_shown;

    // model state
    logic [3:0]             tally [DIGITS];
    logic [PRESET_W-1:0]    preset_val [4];
    scan_word_t             scan_expect_q [$];
    int                     mismatches = 0;

    bit                     pace_src;
    bit                     pace_sink;
    plan_row_t              plan [PLAN_ROWS];

    preset_bcd_counter_segment_scan dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_switch_one_level   (s_switch_one_level),
        .s_switch_two_level   (s_switch_two_level),
        .s_switch_three_level (s_switch_three_level),
        .s_switch_four_level  (s_switch_four_level),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_segment_bits       (m_segment_bits),
        .m_decimal_point      (m_decimal_point),
        .m_digit_index        (m_digit_index),
        .m_last_digit         (m_last_digit),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // preset load by switch priority, six scan words, then one hundredth up
    task automatic count_and_scan(input logic [3:0] levels, input logic typed,
                                  input logic [23:0] shown);
        logic [PRESET_W-1:0] src;
        logic                load;
        logic [3:0]          d;
        scan_word_t          w;
        load = 1'b1;
        src  = '0;
        if (!levels[3]) begin
            src = preset_val[0];
        end else if (!levels[2]) begin
            src = preset_val[1];
        end else if (!levels[1]) begin
            src = preset_val[2];
        end else if (!levels[0]) begin
            src = preset_val[3];
        end else begin
            load = 1'b0;
        end
        if (load) begin
            for (int i = 0; i < DIGITS; i++) begin
                d        = src[4*(DIGITS-1-i) +: 4];
                tally[i] = (d > 4'd9) ? 4'd9 : d;
            end
        end
        // leftmost digit first
        for (int i = 0; i < DIGITS; i++) begin
            d       = typed ? shown[4*(DIGITS-1-i) +: 4] : tally[i];
            w.seg   = SEG_OF[(d > 4'd9) ? 4'd9 : d];
            w.point = (i == POINT_DIGIT);
            w.pos   = DIGIT_IDX_W'(i);
            w.last  = (i == DIGITS - 1);
            scan_expect_q.push_back(w);
        end
        // decimal carry, all nines wrap to zero
        for (int i = DIGITS - 1; i >= 0; i--) begin
            if (tally[i] == 4'd9) begin
                tally[i] = 4'd0;
            end else begin
                tally[i] = tally[i] + 4'd1;
                break;
            end
        end
    endtask

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // model update and word check at every rising edge
    always @(posedge aclk) begin
        scan_word_t want;
        if (!aresetn) begin
            for (int i = 0; i < DIGITS; i++) begin
                tally[i] = POWER_ON_COUNT[4*(DIGITS-1-i) +: 4];
            end
            for (int k = 0; k < 4; k++) begin
                preset_val[k] = POWER_ON_PRESET[k];
            end
            scan_expect_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PRESET_ONE:   preset_val[0] = cfg_data;
                    REG_PRESET_TWO:   preset_val[1] = cfg_data;
                    REG_PRESET_THREE: preset_val[2] = cfg_data;
                    REG_PRESET_FOUR:  preset_val[3] = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                count_and_scan({s_switch_one_level, s_switch_two_level,
                                s_switch_three_level, s_switch_four_level},
                               tick_typed, tick_shown);
            end
            if (m_valid && m_ready) begin
                if (scan_expect_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: scan word with none expected, expected nothing, got %0h",
                             $time, {m_segment_bits, m_decimal_point, m_digit_index,
                                     m_last_digit});
                end else begin
                    want = scan_expect_q.pop_front();
                    compare_field("segment_bits", want.seg, m_segment_bits);
                    compare_field("decimal_point", want.point, m_decimal_point);
                    compare_field("digit_index", want.pos, m_digit_index);
                    compare_field("last_digit", want.last, m_last_digit);
                end
            end
        end
    end

    // result side stalls in random bursts
    initial begin : sink_pacing
        int hold;
        hold    = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (pace_sink && hold == 0 && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 14);
            end
            if (!pace_sink) begin
                hold = 0;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input logic [3:0] levels, input logic typed,
                             input logic [23:0] shown);
        @(negedge aclk);
        s_valid              <= 1'b1;
        s_switch_one_level   <= levels[3];
        s_switch_two_level   <= levels[2];
        s_switch_three_level <= levels[1];
        s_switch_four_level  <= levels[0];
        tick_typed           <= typed;
        tick_shown           <= shown;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic hold_sender(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // stop sending and wait for every expected word
    task automatic await_scan_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (scan_expect_q.size() != 0) @(posedge aclk);
    endtask

    task automatic put_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [PRESET_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        plan_row_t           row;
        logic [3:0]          levels;
        logic [PRESET_W-1:0] val;
        aresetn              = 1'b0;
        s_valid              = 1'b0;
        s_switch_one_level   = 1'b1;
        s_switch_two_level   = 1'b1;
        s_switch_three_level = 1'b1;
        s_switch_four_level  = 1'b1;
        cfg_valid            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        tick_typed           = 1'b0;
        tick_shown           = '0;
        pace_src             = 1'b1;
        pace_sink            = 1'b1;

        plan = '{
            // power-on count, then one plain step
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h199534},
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b0, 24'h000000},
            // each switch alone with default presets
            '{ROW_TICK,  4'b0111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h111111},
            '{ROW_TICK,  4'b1011, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h222222},
            '{ROW_TICK,  4'b1101, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h333333},
            '{ROW_TICK,  4'b1110, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h444444},
            // several pressed, lowest numbered wins
            '{ROW_TICK,  4'b0000, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h111111},
            '{ROW_TICK,  4'b1000, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h222222},
            '{ROW_TICK,  4'b1100, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h333333},
            '{ROW_TICK,  4'b1010, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h222222},
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b0, 24'h000000},
            // extreme presets, nibble clamp, writes to unused indexes
            '{ROW_WRITE, 4'b1111, REG_PRESET_ONE,   24'h999999, 1'b0, 24'h000000},
            '{ROW_WRITE, 4'b1111, REG_PRESET_TWO,   24'hFFFFFF, 1'b0, 24'h000000},
            '{ROW_WRITE, 4'b1111, REG_PRESET_THREE, 24'h000000, 1'b0, 24'h000000},
            '{ROW_WRITE, 4'b1111, REG_PRESET_FOUR,  24'h9A0F59, 1'b0, 24'h000000},
            '{ROW_WRITE, 4'b1111, REG_PAST_LAST,    24'h123456, 1'b0, 24'h000000},
            '{ROW_WRITE, 4'b1111, REG_TOP,          24'h000000, 1'b0, 24'h000000},
            // all nines wraps to zero, clamped presets show nines, preset three shows zero
            '{ROW_TICK,  4'b0111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h999999},
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h000000},
            '{ROW_TICK,  4'b1011, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h999999},
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h000000},
            '{ROW_TICK,  4'b1101, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h000000},
            '{ROW_TICK,  4'b1110, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h990959},
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b0, 24'h000000},
            // unused index writes left preset one alone
            '{ROW_TICK,  4'b0111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h999999},
            '{ROW_TICK,  4'b1111, REG_PRESET_ONE,   24'h000000, 1'b1, 24'h000000}
        };

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_WRITE) begin
                await_scan_drain();
                put_register(row.reg_idx, row.reg_val);
            end else begin
                send_tick(row.levels, row.typed, row.shown);
                if (pace_src && $urandom_range(0, 3) == 0) begin
                    hold_sender($urandom_range(1, 14));
                end
            end
        end

        // random phases, the first writing all presets and later ones a random subset; the last one runs flat out
        for (int phase = 0; phase < 5; phase++) begin
            await_scan_drain();
            for (int k = 0; k < 4; k++) begin
                if (phase == 0 || $urandom_range(0, 2) != 0) begin
                    case ($urandom_range(0, 2))
                        0: val = PRESET_W'($urandom);
                        1: begin
                            for (int j = 0; j < 6; j++) begin
                                val[4*j +: 4] = 4'($urandom_range(0, 9));
                            end
                        end
                        default: val = {20'h99999, 4'($urandom_range(0, 9))};
                    endcase
                    put_register(CFG_INDEX_W'(k), val);
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                put_register($urandom_range(0, 1) ? REG_TOP : REG_PAST_LAST,
                             PRESET_W'($urandom));
            end
            pace_src  = (phase != 4) && (phase != 1);
            pace_sink = (phase != 4) && (phase != 3);
            for (int n = 0; n < 22; n++) begin
                // sender holds off until everything is out
                if (phase == 2 && n == 11) begin
                    await_scan_drain();
                end
                levels = $urandom_range(0, 1) ? 4'b1111 : 4'($urandom_range(0, 15));
                send_tick(levels, 1'b0, 24'h000000);
                if (pace_src && $urandom_range(0, 3) == 0) begin
                    hold_sender($urandom_range(1, 14));
                end
            end
        end

        await_scan_drain();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
